// ----- rtl/button_debounce_long_press_assert.svh -----
// Assertion macros used by the debouncer tick sequencer.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define BDLP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define BDLP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/bdlp_pkg.sv -----
// Types, constants and register map of the button debouncer.
package bdlp_pkg;

	localparam int NUM_PINS  = 28;
	localparam int TIME_BITS = 32;
	localparam int PIN_W     = 5;
	localparam int THR_W     = 16;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [PIN_W-1:0]     pin_t;
	typedef logic [THR_W-1:0]     thr_t;
	typedef logic [NUM_PINS-1:0]  mask_t;

	localparam thr_t DEBOUNCE_RST   = 16'd50;
	localparam thr_t LONG_PRESS_RST = 16'd500;
	localparam mask_t TRACK_RST     = '0;
	localparam pin_t LAST_PIN       = PIN_W'(NUM_PINS - 1);

	// Register index (byte address / 4)
	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_TRACK_MASK = 2'd2
	} reg_idx_t;

	// Configuration seen by the sequencer
	typedef struct packed {
		thr_t  debounce;
		thr_t  long_press;
		mask_t track_mask;
	} cfg_t;

	// Per-pin state read at the current pin
	typedef struct packed {
		logic  deb;
		logic  earlier;
		logic  fired;
		time_t last_t;
		time_t prior_t;
	} pin_rd_t;

	// Per-pin state update controls
	typedef struct packed {
		logic step;       // copy debounced level into earlier level
		logic take;       // accept a level change at the current time
		logic new_level;
		logic clr_fired;
		logic set_fired;
	} pin_wr_t;

	// Tick sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DEB,
		ST_HOLD,
		ST_PRIOR,
		ST_OUT
	} st_t;

endpackage

// ----- rtl/bdlp_if.sv -----
// Valid/ready channel interfaces for tick beats and result beats.
interface bdlp_in_if import bdlp_pkg::*; ();
	logic  valid;
	logic  ready;
	time_t now_ms;
	mask_t pin_levels;

	modport source(output valid, now_ms, pin_levels, input ready);
	modport sink(input valid, now_ms, pin_levels, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ();
	logic  valid;
	logic  ready;
	pin_t  pin_index;
	logic  is_down;
	logic  press_edge;
	logic  release_edge;
	logic  long_press;
	time_t held_ms;
	time_t since_previous_ms;
	logic  last_of_tick;

	modport source(output valid, pin_index, is_down, press_edge, release_edge, long_press,
		held_ms, since_previous_ms, last_of_tick, input ready);
	modport sink(input valid, pin_index, is_down, press_edge, release_edge, long_press,
		held_ms, since_previous_ms, last_of_tick, output ready);
endinterface

// ----- rtl/button_debounce_long_press.sv -----
// Per tick the sequencer walks the pins up to the highest tracked one (all pins when none is
//   tracked) and makes three passes per tracked pin through the shared subtract/compare unit;
//   a stalled result beat holds the walk. A new tick is taken only when idle.
// Reset: arst_n clears all pin state, registers to 50 ms / 500 ms / no pins tracked,
//   and takes effect at once with no clearing pass.
module button_debounce_long_press import bdlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	bdlp_in_if.sink           in_ch,
	bdlp_out_if.source        out_ch
);

	cfg_t    cfg;
	pin_t    pin;
	time_t   now;
	pin_wr_t wr;
	pin_rd_t rd;

	bdlp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdlp_pin_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.pin    (pin),
		.now    (now),
		.wr     (wr),
		.rd     (rd)
	);

	bdlp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.rd     (rd),
		.pin    (pin),
		.now    (now),
		.wr     (wr)
	);

endmodule

// ----- rtl/bdlp_cfg_regs.sv -----
// APB-style configuration registers: debounce time, long-press time, track mask.
module bdlp_cfg_regs import bdlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	thr_t     debounce_q;
	thr_t     long_press_q;
	mask_t    track_mask_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			track_mask_q <= TRACK_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE:   debounce_q   <= pwdata[THR_W-1:0];
				REG_LONG_PRESS: long_press_q <= pwdata[THR_W-1:0];
				REG_TRACK_MASK: track_mask_q <= pwdata[NUM_PINS-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_DEBOUNCE:   prdata = DATA_W'(debounce_q);
			REG_LONG_PRESS: prdata = DATA_W'(long_press_q);
			REG_TRACK_MASK: prdata = DATA_W'(track_mask_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg = '{debounce: debounce_q, long_press: long_press_q, track_mask: track_mask_q};

endmodule

// ----- rtl/bdlp_alu.sv -----
// Shared time unit: modular elapsed time and its compare against a threshold.
module bdlp_alu import bdlp_pkg::*; (
	input  time_t a,
	input  time_t b,
	input  thr_t  thr,
	output time_t diff,
	output logic  ge,
	output logic  gt
);

	time_t thr_ext;

	assign thr_ext = TIME_BITS'(thr);
	assign diff    = a - b;
	assign ge      = (diff >= thr_ext);
	assign gt      = (diff > thr_ext);

endmodule

// ----- rtl/bdlp_pin_store.sv -----
// Per-pin debounce state held in flops, one pin read and written at a time.
module bdlp_pin_store import bdlp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  pin_t    pin,
	input  time_t   now,
	input  pin_wr_t wr,
	output pin_rd_t rd
);

	logic  deb_q     [NUM_PINS];
	logic  earlier_q [NUM_PINS];
	logic  fired_q   [NUM_PINS];
	time_t last_q    [NUM_PINS];
	time_t prior_q   [NUM_PINS];

	// state update at the addressed pin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PINS; i++) begin
				deb_q[i]     <= 1'b0;
				earlier_q[i] <= 1'b0;
				fired_q[i]   <= 1'b0;
				last_q[i]    <= '0;
				prior_q[i]   <= '0;
			end
		end else begin
			if (wr.step) begin
				earlier_q[pin] <= deb_q[pin];
			end
			if (wr.take) begin
				prior_q[pin] <= last_q[pin];
				last_q[pin]  <= now;
				deb_q[pin]   <= wr.new_level;
			end
			if (wr.clr_fired) begin
				fired_q[pin] <= 1'b0;
			end else if (wr.set_fired) begin
				fired_q[pin] <= 1'b1;
			end
		end
	end

	assign rd = '{deb: deb_q[pin], earlier: earlier_q[pin], fired: fired_q[pin],
		last_t: last_q[pin], prior_t: prior_q[pin]};

endmodule

// ----- rtl/bdlp_seq.sv -----
// Tick sequencer: walks the pins, drives the shared time unit, holds the result beat.
module bdlp_seq import bdlp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	bdlp_in_if.sink in_ch,
	bdlp_out_if.source out_ch,
	input  pin_rd_t rd,
	output pin_t    pin,
	output time_t   now,
	output pin_wr_t wr
);

	`include "button_debounce_long_press_assert.svh"

	st_t   state_q, state_d;
	time_t now_q;
	mask_t levels_q;
	pin_t  pin_q;

	// result register
	logic  is_down_q, press_q, release_q, long_q, last_q;
	time_t held_q, since_q;

	// shared unit hookup
	time_t alu_b, alu_diff;
	thr_t  alu_thr;
	logic  alu_ge, alu_gt;

	logic  new_level, rel, fire, higher_tracked;

	bdlp_alu u_alu (
		.a    (now_q),
		.b    (alu_b),
		.thr  (alu_thr),
		.diff (alu_diff),
		.ge   (alu_ge),
		.gt   (alu_gt)
	);

	assign new_level = ~levels_q[pin_q];
	assign rel       = !rd.deb && rd.earlier;
	assign fire      = rd.deb && !rd.fired && alu_gt;

	// any tracked pin above the current one
	always_comb begin
		higher_tracked = 1'b0;
		for (int i = 0; i < NUM_PINS; i++) begin
			if (cfg.track_mask[i] && (i > int'(pin_q))) begin
				higher_tracked = 1'b1;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, unit operand select, pin state writes
	always_comb begin
		state_d = state_q;
		alu_b   = rd.last_t;
		alu_thr = cfg.debounce;
		wr      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				priority if (cfg.track_mask[pin_q]) begin
					state_d = ST_DEB;
				end else if (pin_q == LAST_PIN) begin
					state_d = ST_IDLE;
				end
			end
			ST_DEB: begin
				wr.step      = 1'b1;
				wr.take      = (new_level != rd.deb) && alu_ge;
				wr.new_level = new_level;
				state_d      = ST_HOLD;
			end
			ST_HOLD: begin
				alu_thr      = cfg.long_press;
				wr.clr_fired = rel;
				wr.set_fired = fire;
				state_d      = ST_PRIOR;
			end
			ST_PRIOR: begin
				alu_b   = rd.prior_t;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ch.ready) begin
					state_d = last_q ? ST_IDLE : ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// tick capture and pin counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q <= '0;
		end else begin
			if (state_q == ST_IDLE && in_ch.valid) begin
				pin_q <= '0;
			end else if (state_q == ST_SCAN && !cfg.track_mask[pin_q] && pin_q != LAST_PIN) begin
				pin_q <= pin_q + PIN_W'(1);
			end else if (state_q == ST_OUT && out_ch.ready && !last_q) begin
				pin_q <= pin_q + PIN_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid) begin
			now_q    <= in_ch.now_ms;
			levels_q <= in_ch.pin_levels;
		end
	end

	// result fields, filled over the hold and prior passes
	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD) begin
			is_down_q <= rd.deb;
			press_q   <= rd.deb && !rd.earlier;
			release_q <= rel;
			long_q    <= fire;
			held_q    <= alu_diff;
		end
		if (state_q == ST_PRIOR) begin
			since_q <= alu_diff;
			last_q  <= !higher_tracked;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign pin         = pin_q;
	assign now         = now_q;

	assign out_ch.valid             = (state_q == ST_OUT);
	assign out_ch.pin_index         = pin_q;
	assign out_ch.is_down           = is_down_q;
	assign out_ch.press_edge        = press_q;
	assign out_ch.release_edge      = release_q;
	assign out_ch.long_press        = long_q;
	assign out_ch.held_ms           = held_q;
	assign out_ch.since_previous_ms = since_q;
	assign out_ch.last_of_tick      = last_q;

	`BDLP_ASSERT_IMP(a_busy_excl, in_ch.ready, !out_ch.valid, "tick taken while result pending")
	`BDLP_ASSERT_IMP(a_out_tracked, out_ch.valid, cfg.track_mask[pin_q], "result for untracked pin")
	`BDLP_ASSERT_IMP(a_long_down, out_ch.valid && out_ch.long_press, out_ch.is_down, "long press on released pin")
	`BDLP_ASSERT_IMP(a_press_zero, out_ch.valid && out_ch.press_edge, out_ch.held_ms == '0, "press edge with nonzero hold")
	`BDLP_ASSERT_NXT(a_tick_end, out_ch.valid && out_ch.ready && out_ch.last_of_tick, in_ch.ready, "no return to idle after last beat")

endmodule

// ----- tb/button_debounce_long_press_test.sv -----
// Testbench for the button debouncer: directed and random ticks, every pin report checked.
module button_debounce_long_press_test import bdlp_pkg::*; ();

	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int MAX_WAIT = 14;
	localparam int SETTLE_CYCLES = 160;
	localparam int NUM_PHASES = 6;
	localparam int PHASE_TICKS = 45;

	typedef struct {
		pin_t  pin_index;
		logic  is_down;
		logic  press_edge;
		logic  release_edge;
		logic  long_press;
		time_t held_ms;
		time_t since_previous_ms;
		logic  last_of_tick;
	} pin_report_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	bdlp_in_if  tick_ch();
	bdlp_out_if report_ch();

	button_debounce_long_press u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (tick_ch),
		.out_ch  (report_ch)
	);

	// Shadow of the block's registers and per-pin state
	thr_t  debounce_cfg;
	thr_t  hold_cfg;
	mask_t tracked_pins;
	logic  pin_down [NUM_PINS];
	logic  long_sent [NUM_PINS];
	time_t last_change [NUM_PINS];
	time_t prior_change [NUM_PINS];

	pin_report_t expected_reports[$];
	int          mismatch_count;
	time_t       clock_ms;
	mask_t       raw_levels;
	bit          tick_gaps;
	bit          report_stalls;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("Mismatches found");
		$finish;
	end

	function automatic void clear_shadow();
		debounce_cfg = DEBOUNCE_RST;
		hold_cfg     = LONG_PRESS_RST;
		tracked_pins = TRACK_RST;
		for (int p = 0; p < NUM_PINS; p++) begin
			pin_down[p]     = 1'b0;
			long_sent[p]    = 1'b0;
			last_change[p]  = '0;
			prior_change[p] = '0;
		end
	endfunction

	// Walk the tracked pins of one tick and queue the report of each
	function automatic void debounce_tick(time_t now, mask_t levels);
		pin_report_t batch[$];
		pin_report_t r;
		logic        was_down;
		logic        want_down;
		time_t       age;
		for (int p = 0; p < NUM_PINS; p++) begin
			if (!tracked_pins[p])
				continue;
			was_down  = pin_down[p];
			want_down = ~levels[p];
			age       = now - last_change[p];
			if (want_down != was_down && age >= time_t'(debounce_cfg)) begin
				prior_change[p] = last_change[p];
				last_change[p]  = now;
				pin_down[p]     = want_down;
			end
			if (!pin_down[p] && was_down)
				long_sent[p] = 1'b0;
			age          = now - last_change[p];
			r.long_press = 1'b0;
			if (pin_down[p] && !long_sent[p] && age > time_t'(hold_cfg)) begin
				long_sent[p] = 1'b1;
				r.long_press = 1'b1;
			end
			r.pin_index         = pin_t'(p);
			r.is_down           = pin_down[p];
			r.press_edge        = pin_down[p] && !was_down;
			r.release_edge      = !pin_down[p] && was_down;
			r.held_ms           = age;
			r.since_previous_ms = now - prior_change[p];
			r.last_of_tick      = 1'b0;
			batch.insert(batch.size(), r);
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last_of_tick = 1'b1;
		foreach (batch[i])
			expected_reports.insert(expected_reports.size(), batch[i]);
	endfunction

	// Setup and access phase for the write, then a read-back of the same register
	task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] data);
		logic [DATA_W-1:0] exp_rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEBOUNCE:   debounce_cfg = data[THR_W-1:0];
			REG_LONG_PRESS: hold_cfg = data[THR_W-1:0];
			REG_TRACK_MASK: tracked_pins = data[NUM_PINS-1:0];
			default: ;
		endcase
		case (idx)
			REG_DEBOUNCE:   exp_rd = DATA_W'(debounce_cfg);
			REG_LONG_PRESS: exp_rd = DATA_W'(hold_cfg);
			REG_TRACK_MASK: exp_rd = DATA_W'(tracked_pins);
			default:        exp_rd = '0;
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", exp_rd, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// One tick beat; valid stays high afterwards so a back-to-back beat can follow
	task automatic send_tick(time_t now, mask_t levels);
		int gap;
		if ($urandom_range(0, 19) == 0)
			tick_gaps = !tick_gaps;
		gap = tick_gaps ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.now_ms     <= now;
		tick_ch.pin_levels <= levels;
		do @(posedge clk); while (!(tick_ch.valid && tick_ch.ready));
		debounce_tick(now, levels);
	endtask

	// Drop valid, let every report arrive, then give a tick with no reports time to finish
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void check_field(string name, longint unsigned exp, longint unsigned act);
		if (exp != act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			mismatch_count++;
		end
	endfunction

	// Report sink with random stalls; each beat is checked against the oldest expectation
	initial begin
		int          stall;
		pin_report_t e;
		report_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 19) == 0)
				report_stalls = !report_stalls;
			stall = report_stalls ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				report_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			report_ch.ready <= 1'b1;
			do @(posedge clk); while (!(report_ch.valid && report_ch.ready));
			if (expected_reports.size() == 0) begin
				$error("report beat for pin %0d with none expected", report_ch.pin_index);
				mismatch_count++;
			end else begin
				e = expected_reports.pop_front();
				check_field("pin_index", e.pin_index, report_ch.pin_index);
				check_field("is_down", e.is_down, report_ch.is_down);
				check_field("press_edge", e.press_edge, report_ch.press_edge);
				check_field("release_edge", e.release_edge, report_ch.release_edge);
				check_field("long_press", e.long_press, report_ch.long_press);
				check_field("held_ms", e.held_ms, report_ch.held_ms);
				check_field("since_previous_ms", e.since_previous_ms,
					report_ch.since_previous_ms);
				check_field("last_of_tick", e.last_of_tick, report_ch.last_of_tick);
			end
		end
	end

	// Reset defaults track nothing: ticks give no reports and change nothing
	task automatic test_no_tracked_pins();
		send_tick(32'd100, '0);
		send_tick(32'd200, '1);
		settle();
	endtask

	// Default thresholds: early press rejected, press, long press once, release, bounce
	task automatic test_press_and_hold();
		write_reg(REG_TRACK_MASK, 32'hFFFF_FFFF);
		send_tick(32'd10, '0);
		send_tick(32'd60, '0);
		send_tick(32'd561, '0);
		send_tick(32'd600, '0);
		send_tick(32'd700, '1);
		send_tick(32'd701, '0);
		settle();
	endtask

	// Zero debounce and zero hold time across the 32-bit time wrap; upper data bits dropped
	task automatic test_time_wrap_zero_thresholds();
		write_reg(REG_DEBOUNCE, 32'hABCD_0000);
		write_reg(REG_LONG_PRESS, 32'h1234_0000);
		write_reg(REG_TRACK_MASK, 32'hA555_5555);
		send_tick(32'hFFFF_FFF0, '0);
		send_tick(32'hFFFF_FFFF, '0);
		send_tick(32'h0000_0005, '1);
		send_tick(32'h0000_0005, '0);
		send_tick(32'h0000_0006, '0);
		settle();
	endtask

	// Largest thresholds on the outermost pins; a write past the register map is ignored
	task automatic test_max_thresholds();
		write_reg(REG_DEBOUNCE, 32'h0000_FFFF);
		write_reg(REG_LONG_PRESS, 32'h0000_FFFF);
		write_reg(REG_TRACK_MASK, 32'hF800_0001);
		write_reg(REG_UNMAPPED, 32'h0000_0000);
		send_tick(32'h8000_0000, '0);
		send_tick(32'h8000_0010, '1);
		send_tick(32'h8000_FFFF, '0);
		send_tick(32'h8001_FFFF, '0);
		send_tick(32'h8002_0000, '1);
		settle();
	endtask

	// Phases of new settings, each with button activity: mostly steady time and sparse
	// level flips, with some time jumps and fully random levels as noise
	task automatic test_random_presses();
		logic [DATA_W-1:0] value;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_DEBOUNCE, 32'h0);
					write_reg(REG_LONG_PRESS, 32'h0);
					write_reg(REG_TRACK_MASK, 32'hFFFF_FFFF);
				end
				1: begin
					write_reg(REG_DEBOUNCE, 32'hFFFF_FFFF);
					write_reg(REG_LONG_PRESS, 32'hFFFF_FFFF);
					write_reg(REG_TRACK_MASK, 32'h0FFF_FFFF);
				end
				default: begin
					value = {16'($urandom), 16'($urandom_range(0, 100))};
					write_reg(REG_DEBOUNCE, value);
					value = {16'($urandom), 16'($urandom_range(0, 600))};
					write_reg(REG_LONG_PRESS, value);
					case ($urandom_range(0, 3))
						0: value = 32'hFFFF_FFFF;
						1: value = 32'd1 << $urandom_range(0, NUM_PINS - 1);
						default: value = $urandom;
					endcase
					write_reg(REG_TRACK_MASK, value);
				end
			endcase
			for (int i = 0; i < PHASE_TICKS; i++) begin
				case ($urandom_range(0, 9))
					0: clock_ms = $urandom;
					1: raw_levels = mask_t'($urandom);
					default: begin
						clock_ms += $urandom_range(0, 120);
						raw_levels ^= mask_t'($urandom & $urandom & $urandom);
					end
				endcase
				send_tick(clock_ms, raw_levels);
			end
			settle();
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		tick_ch.valid      <= 1'b0;
		tick_ch.now_ms     <= '0;
		tick_ch.pin_levels <= '1;
		mismatch_count = 0;
		clock_ms       = '0;
		raw_levels     = '1;
		tick_gaps      = 1'b1;
		report_stalls  = 1'b1;
		clear_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_tracked_pins();
		test_press_and_hold();
		test_time_wrap_zero_thresholds();
		test_max_thresholds();
		test_random_presses();
		settle();
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- button_debounce_long_press.f -----
+incdir+rtl
rtl/bdlp_pkg.sv
rtl/bdlp_if.sv
rtl/bdlp_cfg_regs.sv
rtl/bdlp_alu.sv
rtl/bdlp_pin_store.sv
rtl/bdlp_seq.sv
rtl/button_debounce_long_press.sv
tb/button_debounce_long_press_test.sv
